FILE: hdl/lslf_pkg.sv
// shared constants, conversion tables and handoff types for the lux filter
package lslf_pkg;

    // sizing of the sample path
    localparam int SAMPLES_PER_READING = 20;
    localparam int WINDOW_DEPTH        = 6;
    localparam int TABLE_POINTS        = 17;
    localparam int FRAC_BITS           = 10;

    // field widths
    localparam int MV_W    = 16;
    localparam int LUX_W   = 15;
    localparam int MV_PT_W = 12;
    localparam int SUM_W   = $clog2(SAMPLES_PER_READING * 65535 + 1);
    localparam int CNT_W   = $clog2(SAMPLES_PER_READING + 1);
    localparam int K_W     = $clog2(TABLE_POINTS + 1);
    localparam int IDX_W   = $clog2(TABLE_POINTS);
    localparam int POS_W   = $clog2(WINDOW_DEPTH);
    localparam int WSUM_W  = LUX_W + $clog2(WINDOW_DEPTH);
    localparam int FRAC_Q_W = FRAC_BITS + 1;
    localparam int PROD_W  = LUX_W + FRAC_Q_W;

    // mean by reciprocal multiplication, exact while the sum times the rounding error
    // stays below two to the shift
    localparam int MEAN_SHIFT  = 25;
    localparam int MEAN_RECIP  = ((1 << MEAN_SHIFT) + SAMPLES_PER_READING - 1)
                                 / SAMPLES_PER_READING;
    localparam int MEAN_PROD_W = SUM_W + $clog2(MEAN_RECIP + 1);

    // shared divider sizing: dividend covers the scaled segment offset
    localparam int DIV_W     = MV_PT_W + FRAC_BITS;
    localparam int DVS_W     = MV_PT_W;
    localparam int DIV_CNT_W = $clog2(DIV_W + 1);

    // millivolt breakpoints, ascending
    localparam logic [MV_PT_W-1:0] MV_POINTS [TABLE_POINTS] = '{
        12'd29,  12'd31,  12'd37,  12'd72,  12'd160, 12'd220, 12'd502, 12'd503,
        12'd515, 12'd520, 12'd654, 12'd851, 12'd863, 12'd893, 12'd900, 12'd1250,
        12'd3300
    };

    // lux value at each breakpoint
    localparam logic [LUX_W-1:0] LUX_POINTS [TABLE_POINTS] = '{
        15'd0,    15'd35,   15'd65,   15'd88,   15'd230,  15'd400,  15'd623,  15'd668,
        15'd670,  15'd684,  15'd725,  15'd1250, 15'd1290, 15'd1340, 15'd1954, 15'd4000,
        15'd20000
    };

    // shared divider request and response
    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DVS_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
    } div_rsp_t;

    // window update and scan request and response
    typedef struct packed {
        logic             start;
        logic             fill;
        logic [POS_W-1:0] slot;
        logic [LUX_W-1:0] value;
    } win_req_t;

    typedef struct packed {
        logic              done;
        logic [WSUM_W-1:0] trimmed;
    } win_rsp_t;

endpackage

FILE: hdl/light_sample_to_lux_filter_unit.sv
// lux filter top level: sample accumulation, table interpolation and window sequencer
//
//  channel   dir  handshake                        payload
//  s_axis    in   s_axis_tvalid / s_axis_tready     tdata conversion_word, tuser restart
//  m_axis    out  m_axis_tvalid / m_axis_tready     tdata lux, raw_lux, mean_millivolts
//  cfg       in   cfg_valid / cfg_ready             cfg_data average_enable
//
// a sample that does not complete a reading is taken while the input stays open
// a completing sample closes the input while the reading is worked: the reciprocal
// mean, the table search, the shared divider, multiply and add on the segment fraction
// (skipped at the table ends and on a zero span), window setup and scan when averaging
// is enabled, and loading the output register; the divider is the longest step
// s_axis_tready is low while a reading is worked on and while its item waits for the
// output register; an item already in the output register waits there for m_axis_tready
// reset clears the partial sum, count, window position, fill flag and mode
module light_sample_to_lux_filter_unit
(
    input  logic        clk,
    input  logic        rst_n,
    // tdata: conversion_word[31:0]
    input  logic [31:0] s_axis_tdata,
    // tuser: restart[0]
    input  logic [0:0]  s_axis_tuser,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata: lux[14:0], raw_lux[29:15], mean_millivolts[45:30], zero[47:46]
    output logic [47:0] m_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // average_enable
    input  logic [0:0]  cfg_data,
    input  logic        cfg_valid,
    output logic        cfg_ready
);
    import lslf_pkg::*;

    typedef enum logic [8:0] {
        ST_IDLE   = 9'b000000001,
        ST_MEAN   = 9'b000000010,
        ST_SEARCH = 9'b000000100,
        ST_FRAC   = 9'b000001000,
        ST_MUL    = 9'b000010000,
        ST_ADD    = 9'b000100000,
        ST_POST   = 9'b001000000,
        ST_SCAN   = 9'b010000000,
        ST_FINISH = 9'b100000000
    } state_t;

    state_t               state_reg, state_next;
    logic [SUM_W-1:0]     sum_reg, sum_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic                 avg_reg, avg_next;
    logic [POS_W-1:0]     pos_reg, pos_next;
    logic                 filled_reg, filled_next;
    logic [MV_W-1:0]      mean_reg, mean_next;
    logic [K_W-1:0]       k_reg, k_next;
    logic [FRAC_Q_W-1:0]  frac_reg, frac_next;
    logic [PROD_W-1:0]    prod_reg, prod_next;
    logic [LUX_W-1:0]     raw_reg, raw_next;
    logic [LUX_W-1:0]     lux_reg, lux_next;
    logic                 out_valid_reg, out_valid_next;
    logic [LUX_W-1:0]     out_lux_reg, out_lux_next;
    logic [LUX_W-1:0]     out_raw_reg, out_raw_next;
    logic [MV_W-1:0]      out_mean_reg, out_mean_next;

    div_req_t             div_req;
    div_rsp_t             div_rsp;
    win_req_t             win_req;
    win_rsp_t             win_rsp;

    logic                 accept;
    logic [MV_W-1:0]      sample_mv;
    logic [SUM_W-1:0]     sum_acc;
    logic [CNT_W-1:0]     cnt_acc;
    logic [MEAN_PROD_W-1:0] mean_prod;
    logic [IDX_W-1:0]     ki;
    logic [IDX_W-1:0]     ki_prev;
    logic                 k_in;
    logic                 k_prev_in;
    logic [MV_PT_W-1:0]   pt_cur;
    logic [MV_PT_W-1:0]   pt_prev;
    logic [LUX_W-1:0]     lux_cur;
    logic [LUX_W-1:0]     lux_prev;
    logic [MV_PT_W-1:0]   span;
    logic [MV_PT_W-1:0]   offset;
    logic [LUX_W-1:0]     rise;
    logic                 search_stop;
    logic                 out_free;

    // handshakes
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign cfg_ready     = 1'b1;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !out_valid_reg || m_axis_tready;

    // sample accumulation
    assign sample_mv = s_axis_tdata[31:16];
    assign sum_acc   = (s_axis_tuser[0] ? '0 : sum_reg) + SUM_W'(sample_mv);
    assign cnt_acc   = (s_axis_tuser[0] ? '0 : count_reg) + 1'b1;

    // mean of a full reading from the held sum
    assign mean_prod = MEAN_PROD_W'(sum_reg) * MEAN_PROD_W'(MEAN_RECIP);

    // table lookups around the current search index
    assign ki        = k_reg[IDX_W-1:0];
    assign ki_prev   = IDX_W'(k_reg - 1'b1);
    assign k_in      = (k_reg < K_W'(TABLE_POINTS));
    assign k_prev_in = (k_reg != '0) && (k_reg <= K_W'(TABLE_POINTS));
    assign pt_cur    = k_in ? MV_POINTS[ki] : '0;
    assign pt_prev   = k_prev_in ? MV_POINTS[ki_prev] : '0;
    assign lux_cur   = k_in ? LUX_POINTS[ki] : '0;
    assign lux_prev  = k_prev_in ? LUX_POINTS[ki_prev] : '0;
    assign span      = pt_cur - pt_prev;
    assign offset    = mean_reg[MV_PT_W-1:0] - pt_prev;
    assign rise      = (lux_cur >= lux_prev) ? lux_cur - lux_prev : '0;
    assign search_stop = !k_in || !(MV_W'(pt_cur) < mean_reg);

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        sum_next       = sum_reg;
        count_next     = count_reg;
        avg_next       = avg_reg;
        pos_next       = pos_reg;
        filled_next    = filled_reg;
        mean_next      = mean_reg;
        k_next         = k_reg;
        frac_next      = frac_reg;
        prod_next      = prod_reg;
        raw_next       = raw_reg;
        lux_next       = lux_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_lux_next   = out_lux_reg;
        out_raw_next   = out_raw_reg;
        out_mean_next  = out_mean_reg;
        div_req        = '0;
        win_req        = '0;

        if (cfg_valid && cfg_ready)
        begin
            avg_next = cfg_data[0];
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (s_axis_tuser[0])
                    begin
                        filled_next = 1'b1 ^ 1'b1;
                    end
                    // a full reading keeps its sum for the mean step
                    sum_next = sum_acc;
                    if (cnt_acc == CNT_W'(SAMPLES_PER_READING))
                    begin
                        count_next = '0;
                        state_next = ST_MEAN;
                    end
                    else
                    begin
                        count_next = cnt_acc;
                    end
                end
            end
            ST_MEAN:
            begin
                mean_next  = mean_prod[MEAN_SHIFT +: MV_W];
                sum_next   = '0;
                k_next     = '0;
                state_next = ST_SEARCH;
            end
            ST_SEARCH:
            begin
                // first breakpoint not below the mean
                if (!search_stop)
                begin
                    k_next = k_reg + 1'b1;
                end
                else if (k_reg == '0)
                begin
                    raw_next   = LUX_POINTS[0];
                    state_next = ST_POST;
                end
                else if (!k_in)
                begin
                    raw_next   = LUX_POINTS[TABLE_POINTS-1];
                    state_next = ST_POST;
                end
                else if (span == '0)
                begin
                    raw_next   = lux_cur;
                    state_next = ST_POST;
                end
                else
                begin
                    div_req.start    = 1'b1;
                    div_req.dividend = DIV_W'({offset, FRAC_BITS'(0)});
                    div_req.divisor  = span;
                    state_next       = ST_FRAC;
                end
            end
            ST_FRAC:
            begin
                if (div_rsp.done)
                begin
                    frac_next  = div_rsp.quotient[FRAC_Q_W-1:0];
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                prod_next  = PROD_W'(rise) * PROD_W'(frac_reg);
                state_next = ST_ADD;
            end
            ST_ADD:
            begin
                raw_next   = LUX_W'(prod_reg[PROD_W-1:FRAC_BITS]
                                    + (PROD_W - FRAC_BITS)'(lux_prev));
                state_next = ST_POST;
            end
            ST_POST:
            begin
                if (avg_reg)
                begin
                    // an empty window takes the reading in every entry
                    win_req.start = 1'b1;
                    win_req.fill  = !filled_reg;
                    win_req.slot  = pos_reg;
                    win_req.value = raw_reg;
                    filled_next   = 1'b1;
                    pos_next      = (pos_reg == POS_W'(WINDOW_DEPTH - 1)) ? '0
                                                                          : pos_reg + 1'b1;
                    state_next    = ST_SCAN;
                end
                else
                begin
                    lux_next   = raw_reg;
                    state_next = ST_FINISH;
                end
            end
            ST_SCAN:
            begin
                // trimmed sum without the largest and smallest entries, power of two divisor
                if (win_rsp.done)
                begin
                    lux_next   = LUX_W'(win_rsp.trimmed / WSUM_W'(WINDOW_DEPTH - 2));
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_lux_next   = lux_reg;
                    out_raw_next   = raw_reg;
                    out_mean_next  = mean_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            sum_reg       <= '0;
            count_reg     <= '0;
            avg_reg       <= 1'b0;
            pos_reg       <= '0;
            filled_reg    <= 1'b0;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sum_reg       <= sum_next;
            count_reg     <= count_next;
            avg_reg       <= avg_next;
            pos_reg       <= pos_next;
            filled_reg    <= filled_next;
            k_reg         <= k_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        mean_reg     <= mean_next;
        frac_reg     <= frac_next;
        prod_reg     <= prod_next;
        raw_reg      <= raw_next;
        lux_reg      <= lux_next;
        out_lux_reg  <= out_lux_next;
        out_raw_reg  <= out_raw_next;
        out_mean_reg <= out_mean_next;
    end

    // shared divider
    lslf_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // reading window
    lslf_win u_win
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (win_req),
        .rsp   (win_rsp)
    );

    // output item
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {2'b00, out_mean_reg, out_raw_reg, out_lux_reg};

    // the partial count never reaches a full reading
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg < CNT_W'(SAMPLES_PER_READING))
        else $error("sample count reached a full reading");

    // the mean of millivolt samples fits in the mean field
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MEAN) |-> mean_prod[MEAN_PROD_W-1:MEAN_SHIFT+MV_W] == '0)
        else $error("mean overflows millivolt width");

    // search index stays within one past the table
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SEARCH) |-> k_reg <= K_W'(TABLE_POINTS))
        else $error("table search ran past the end");

    // once a window pass finishes, the window counts as filled
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN && win_rsp.done) |-> filled_reg)
        else $error("window scanned while not marked filled");

endmodule

FILE: hdl/lslf_div.sv
// shared restoring divider, one quotient bit per cycle
module lslf_div
(
    input  logic                clk,
    input  logic                rst_n,
    input  lslf_pkg::div_req_t  req,
    output lslf_pkg::div_rsp_t  rsp
);
    import lslf_pkg::*;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DVS_W-1:0]     rem_reg, rem_next;
    logic [DVS_W-1:0]     dvs_reg, dvs_next;
    logic [DIV_W-1:0]     quo_reg, quo_next;

    logic [DVS_W:0]       trial;
    logic                 fits;

    // one restoring step
    assign trial = {rem_reg, quo_reg[DIV_W-1]};
    assign fits  = (trial >= {1'b0, dvs_reg});

    // sequencing of the iterations
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        quo_next  = quo_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = DIV_CNT_W'(DIV_W);
            rem_next  = '0;
            dvs_next  = req.divisor;
            quo_next  = req.dividend;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? DVS_W'(trial - {1'b0, dvs_reg}) : trial[DVS_W-1:0];
            quo_next = {quo_reg[DIV_W-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // operand and partial result registers
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        quo_reg <= quo_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

FILE: hdl/lslf_win.sv
// reading window: scans sum, max and min one entry a cycle, writing the new reading as it passes
module lslf_win
(
    input  logic                clk,
    input  logic                rst_n,
    input  lslf_pkg::win_req_t  req,
    output lslf_pkg::win_rsp_t  rsp
);
    import lslf_pkg::*;

    logic [LUX_W-1:0]  win_reg [WINDOW_DEPTH];

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [POS_W-1:0]  j_reg, j_next;
    logic              fill_reg, fill_next;
    logic [POS_W-1:0]  slot_reg, slot_next;
    logic [LUX_W-1:0]  value_reg, value_next;
    logic [WSUM_W-1:0] total_reg, total_next;
    logic [LUX_W-1:0]  hi_reg, hi_next;
    logic [LUX_W-1:0]  lo_reg, lo_next;

    logic              hit;
    logic              first;
    logic              last;
    logic [LUX_W-1:0]  elem;

    // entry seen at this step, the new reading where it is written
    assign hit   = fill_reg || (j_reg == slot_reg);
    assign elem  = hit ? value_reg : win_reg[j_reg];
    assign first = (j_reg == '0);
    assign last  = (j_reg == POS_W'(WINDOW_DEPTH - 1));

    // scan sequencing and running sum, max, min
    always_comb
    begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        j_next     = j_reg;
        fill_next  = fill_reg;
        slot_next  = slot_reg;
        value_next = value_reg;
        total_next = total_reg;
        hi_next    = hi_reg;
        lo_next    = lo_reg;
        if (req.start)
        begin
            busy_next  = 1'b1;
            j_next     = '0;
            fill_next  = req.fill;
            slot_next  = req.slot;
            value_next = req.value;
        end
        else if (busy_reg)
        begin
            total_next = (first ? '0 : total_reg) + WSUM_W'(elem);
            hi_next    = (first || elem > hi_reg) ? elem : hi_reg;
            lo_next    = (first || elem < lo_reg) ? elem : lo_reg;
            j_next     = j_reg + 1'b1;
            if (last)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
                j_next    = '0;
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            j_reg    <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            j_reg    <= j_next;
        end
    end

    // payload and window entries
    always_ff @(posedge clk)
    begin
        fill_reg  <= fill_next;
        slot_reg  <= slot_next;
        value_reg <= value_next;
        total_reg <= total_next;
        hi_reg    <= hi_next;
        lo_reg    <= lo_next;
        if (busy_reg && hit)
        begin
            win_reg[j_reg] <= value_reg;
        end
    end

    assign rsp.done    = done_reg;
    assign rsp.trimmed = total_reg - WSUM_W'(hi_reg) - WSUM_W'(lo_reg);

endmodule
